### hdl/round_robin_schedule_stepper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin schedule stepper
// Clocked, reset-gated concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SCHEDULE_STEPPER_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULE_STEPPER_ASSERT_SVH

// explicit clock and active-low reset
`define RRSS_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// default clock and reset names
`define RRSS_ASSERT(lbl, prop, msg) \
  `RRSS_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/rrss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared widths, mode codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int MODE_W     = 2;
  localparam int BURST_IN_W = 16;
  localparam int QUANT_W    = 16;
  localparam int TIME_W     = 22;
  localparam int JOB_W      = 6;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic search;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

### hdl/rrss_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_in_if
// Request channel: mode and burst length with valid/ready.
// ----------------------------------------------------------------------------
interface rrss_in_if;
  logic                             valid;
  logic                             ready;
  logic [rrss_pkg::MODE_W-1:0]      mode;
  logic [rrss_pkg::BURST_IN_W-1:0]  burst_time;

  modport source (output valid, output mode, output burst_time, input ready);
  modport sink   (input valid, input mode, input burst_time, output ready);
endinterface

### hdl/rrss_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_out_if
// Result channel: one scheduled slice or an all-done marker.
// ----------------------------------------------------------------------------
interface rrss_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrss_pkg::JOB_W-1:0]   job_number;
  logic [rrss_pkg::TIME_W-1:0]  slice_start;
  logic [rrss_pkg::TIME_W-1:0]  slice_end;
  logic                         job_finished;
  logic [rrss_pkg::TIME_W-1:0]  waiting_time;
  logic [rrss_pkg::TIME_W-1:0]  turnaround_time;
  logic                         all_done;

  modport source (output valid, output job_number, output slice_start, output slice_end,
                  output job_finished, output waiting_time, output turnaround_time,
                  output all_done, input ready);
  modport sink   (input valid, input job_number, input slice_start, input slice_end,
                  input job_finished, input waiting_time, input turnaround_time,
                  input all_done, output ready);
endinterface

### hdl/rrss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer: decodes requests and walks a step through search, execute (when a job is found) and emit.
// ----------------------------------------------------------------------------
module rrss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [rrss_pkg::MODE_W-1:0] in_mode_i,
  output logic                        in_ready_o,
  input  rrss_pkg::sts_t              sts_i,
  output rrss_pkg::cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign xfer       = in_ready_o & in_valid_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = xfer & (in_mode_i == rrss_pkg::MODE_LOAD);
    cmd_o.clear  = xfer & (in_mode_i == rrss_pkg::MODE_CLEAR);
    cmd_o.start  = xfer & (in_mode_i == rrss_pkg::MODE_STEP);
    cmd_o.search = (state_q == S_SEARCH);
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.emit   = (state_q == S_EMIT) & sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.start) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts_i.hit)            state_d = S_EXEC;
        else if (sts_i.exhausted) state_d = S_EMIT;
      end
      S_EXEC: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/rrss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_dp
// Datapath: job memory, active mask with word-wise scan, clock and result reg.
// ----------------------------------------------------------------------------
module rrss_dp #(
  parameter int MAX_JOBS   = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rrss_pkg::BURST_IN_W-1:0] burst_i,
  input  logic                            cfg_we_i,
  input  logic [rrss_pkg::QUANT_W-1:0]    cfg_wdata_i,
  input  rrss_pkg::cmd_t                  cmd_i,
  output rrss_pkg::sts_t                  sts_o,
  rrss_out_if.source                      rsp_o
);

  localparam int TW     = rrss_pkg::TIME_W;
  localparam int QW     = rrss_pkg::QUANT_W;
  localparam int IW     = $clog2(MAX_JOBS);
  localparam int CNTW   = $clog2(MAX_JOBS + 1);
  localparam int SW     = (BURST_BITS < rrss_pkg::BURST_IN_W) ? BURST_BITS
                                                              : rrss_pkg::BURST_IN_W;
  localparam int CHUNK  = (IW < 5) ? (1 << IW) : 32;
  localparam int OW     = $clog2(CHUNK);
  localparam int NCHUNK = (MAX_JOBS + CHUNK - 1) / CHUNK;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int VW     = $clog2(NCHUNK + 1);

  // {burst, remaining}
  logic [2*SW-1:0] mem [MAX_JOBS];
  logic [2*SW-1:0] rdata_q;

  logic [NCHUNK-1:0][CHUNK-1:0] mask_q;
  logic [CNTW-1:0]              count_q;
  logic [TW-1:0]                clock_q;
  logic [IW-1:0]                scan_q;
  logic [QW-1:0]                quant_q;

  logic [CIW-1:0] chunk_q;
  logic [VW-1:0]  visit_q;
  logic [IW-1:0]  found_q;
  logic           done_q;
  logic [TW-1:0]  start_q;
  logic           fin_q;

  logic                 out_valid_q;
  logic [rrss_pkg::JOB_W-1:0] job_q;
  logic [TW-1:0]        slice_start_q, slice_end_q, wait_q, turn_q;
  logic                 finished_q, all_done_q;

  // scan of one mask word
  logic [CHUNK-1:0] lower_bound, cand;
  logic [OW-1:0]    hit_off;
  logic [IW-1:0]    hit_idx;
  logic [CIW-1:0]   chunk_next;
  logic             hit;

  always_comb begin
    lower_bound = (visit_q == '0) ? ({CHUNK{1'b1}} << scan_q[OW-1:0]) : {CHUNK{1'b1}};
    cand        = mask_q[chunk_q] & lower_bound;
    hit         = |cand;
    hit_off     = '0;
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (cand[k]) hit_off = OW'(k);
    end
    hit_idx    = IW'({chunk_q, hit_off});
    chunk_next = (chunk_q == CIW'(NCHUNK - 1)) ? '0 : chunk_q + 1'b1;
  end

  assign sts_o.hit       = cmd_i.search & hit;
  assign sts_o.exhausted = (visit_q == VW'(NCHUNK));
  assign sts_o.out_free  = ~out_valid_q | rsp_o.ready;

  // slice arithmetic
  logic [SW-1:0]   rem, burst_rd, new_rem;
  logic [QW-1:0]   q_eff, rem_x, run;
  logic [CNTW-1:0] nxt;
  logic [SW-1:0]   burst_s;
  logic            load_ok;
  logic [IW-1:0]   load_idx;

  always_comb begin
    rem      = rdata_q[SW-1:0];
    burst_rd = rdata_q[2*SW-1:SW];
    q_eff    = (quant_q == '0) ? QW'(1) : quant_q;
    rem_x    = QW'(rem);
    run      = (rem_x > q_eff) ? q_eff : rem_x;
    new_rem  = SW'(rem_x - run);
    nxt      = CNTW'(found_q) + 1'b1;
    burst_s  = SW'(burst_i);
    load_ok  = cmd_i.load & (count_q < CNTW'(MAX_JOBS));
    load_idx = count_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem[load_idx] <= {burst_s, burst_s};
    end else if (cmd_i.exec) begin
      mem[found_q] <= {burst_rd, new_rem};
    end
    if (sts_o.hit) begin
      rdata_q <= mem[hit_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      count_q <= '0;
      clock_q <= '0;
      scan_q  <= '0;
      quant_q <= QW'(1);
      chunk_q <= '0;
      visit_q <= '0;
      found_q <= '0;
      done_q  <= 1'b0;
      start_q <= '0;
      fin_q   <= 1'b0;
    end else begin
      if (cfg_we_i) quant_q <= cfg_wdata_i;
      if (cmd_i.clear) begin
        mask_q  <= '0;
        count_q <= '0;
        clock_q <= '0;
        scan_q  <= '0;
      end
      if (load_ok) begin
        mask_q[CIW'(load_idx >> OW)][load_idx[OW-1:0]] <= (burst_s != '0);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.start) begin
        chunk_q <= CIW'(scan_q >> OW);
        visit_q <= '0;
        done_q  <= 1'b0;
      end
      if (cmd_i.search) begin
        if (hit) begin
          found_q <= hit_idx;
        end else begin
          chunk_q <= chunk_next;
          visit_q <= visit_q + 1'b1;
          if (sts_o.exhausted) done_q <= 1'b1;
        end
      end
      if (cmd_i.exec) begin
        if (new_rem == '0) mask_q[CIW'(found_q >> OW)][found_q[OW-1:0]] <= 1'b0;
        start_q <= clock_q;
        clock_q <= clock_q + TW'(run);
        fin_q   <= (new_rem == '0);
        scan_q  <= (nxt >= count_q) ? '0 : IW'(nxt);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (done_q) begin
        job_q         <= '0;
        slice_start_q <= '0;
        slice_end_q   <= '0;
        finished_q    <= 1'b0;
        wait_q        <= '0;
        turn_q        <= '0;
        all_done_q    <= 1'b1;
      end else begin
        job_q         <= rrss_pkg::JOB_W'(found_q);
        slice_start_q <= start_q;
        slice_end_q   <= clock_q;
        finished_q    <= fin_q;
        wait_q        <= fin_q ? clock_q - TW'(burst_rd) : '0;
        // burst + wait equals the end time modulo the clock width
        turn_q        <= fin_q ? clock_q : '0;
        all_done_q    <= 1'b0;
      end
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.job_number      = job_q;
  assign rsp_o.slice_start     = slice_start_q;
  assign rsp_o.slice_end       = slice_end_q;
  assign rsp_o.job_finished    = finished_q;
  assign rsp_o.waiting_time    = wait_q;
  assign rsp_o.turnaround_time = turn_q;
  assign rsp_o.all_done        = all_done_q;

endmodule

### hdl/round_robin_schedule_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_schedule_stepper
// Round-robin time-slice scheduler over a loaded set of jobs.
// ----------------------------------------------------------------------------
// Load, clear and unused-mode requests complete in the cycle they transfer;
// the block is ready again the next cycle. A step request that serves a job
// passes through the transfer, a mask scan of W words (the last one also
// reads the job memory), one write-back and the loading of the result
// register before the block is ready again. W (1 to NCHUNK + 1) is the
// number of 32-bit words of the active-job mask scanned from the last served
// job to the next job with time left (NCHUNK = MAX_JOBS / 32 rounded up, at
// least 1). A step that finds no job left scans NCHUNK + 1 words and has
// no write-back. If the result register is still occupied, the step holds
// until it is taken. The time quantum may be written only while idle.
module round_robin_schedule_stepper #(
  parameter int MAX_JOBS   = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rrss_in_if.sink                      req_i,
  rrss_out_if.source                   rsp_o,
  input  logic                         cfg_we_i,
  input  logic [rrss_pkg::QUANT_W-1:0] cfg_wdata_i
);

  rrss_pkg::cmd_t cmd;
  rrss_pkg::sts_t sts;
  logic           ready;

  assign req_i.ready = ready;

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_mode_i  (req_i.mode),
    .in_ready_o (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrss_dp #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (req_i.burst_time),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

### hdl/rrss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_checker
// Port-level checks on the scheduler's request and result channels.
// ----------------------------------------------------------------------------
`include "round_robin_schedule_stepper_assert.svh"

module rrss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [rrss_pkg::MODE_W-1:0] in_mode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rrss_pkg::JOB_W-1:0]  job_number_i,
  input logic [rrss_pkg::TIME_W-1:0] slice_start_i,
  input logic [rrss_pkg::TIME_W-1:0] slice_end_i,
  input logic                        job_finished_i,
  input logic [rrss_pkg::TIME_W-1:0] waiting_time_i,
  input logic [rrss_pkg::TIME_W-1:0] turnaround_time_i,
  input logic                        all_done_i
);

  `RRSS_ASSERT(a_step_busy, in_valid_i && in_ready_i && in_mode_i == rrss_pkg::MODE_STEP |=> !in_ready_i, "step transfer not followed by busy")
  `RRSS_ASSERT(a_done_clean, out_valid_i && all_done_i |-> job_number_i == 0 && slice_start_i == 0 && slice_end_i == 0 && !job_finished_i && waiting_time_i == 0 && turnaround_time_i == 0, "all-done result carries nonzero fields")
  `RRSS_ASSERT(a_turn_end, out_valid_i && job_finished_i |-> turnaround_time_i == slice_end_i, "turnaround differs from completion time")
  `RRSS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `RRSS_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(job_number_i) && $stable(slice_end_i) && $stable(all_done_i), "result changed while stalled")

endmodule

bind round_robin_schedule_stepper rrss_checker u_rrss_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .in_mode_i         (req_i.mode),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .job_number_i      (rsp_o.job_number),
  .slice_start_i     (rsp_o.slice_start),
  .slice_end_i       (rsp_o.slice_end),
  .job_finished_i    (rsp_o.job_finished),
  .waiting_time_i    (rsp_o.waiting_time),
  .turnaround_time_i (rsp_o.turnaround_time),
  .all_done_i        (rsp_o.all_done)
);

### tb/round_robin_schedule_stepper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_schedule_stepper_test
// Self-checking bench for the round-robin slice scheduler. Requests are
// driven through the request channel with random gaps, and results are
// taken with random back-pressure. A scoreboard model of the job set,
// clock and scan position predicts every slice, completion and all-done
// marker. The time quantum is rewritten between phases, only while idle.
// ----------------------------------------------------------------------------
module round_robin_schedule_stepper_test;

  localparam int MAX_JOBS = 64;
  localparam int TARGET_ITEMS = 600;
  localparam int STALL_LIMIT = 4000;
  localparam logic [rrss_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [rrss_pkg::JOB_W-1:0]  job;
    logic [rrss_pkg::TIME_W-1:0] t_start;
    logic [rrss_pkg::TIME_W-1:0] t_end;
    logic                        fin;
    logic [rrss_pkg::TIME_W-1:0] waited;
    logic [rrss_pkg::TIME_W-1:0] tat;
    logic                        all_done;
  } slice_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [rrss_pkg::QUANT_W-1:0] cfg_wdata;

  rrss_in_if  req_if ();
  rrss_out_if rsp_if ();

  round_robin_schedule_stepper #(
    .MAX_JOBS  (MAX_JOBS),
    .BURST_BITS(16)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // scheduler model state
  logic [15:0]                  left_mem  [MAX_JOBS];
  logic [15:0]                  burst_mem [MAX_JOBS];
  int                           jobs = 0;
  int                           scan = 0;
  logic [rrss_pkg::TIME_W-1:0]  now_t = '0;
  logic [rrss_pkg::QUANT_W-1:0] quantum = 16'd1;
  bit                           last_done = 1'b0;

  slice_t slice_q[$];

  int gap_pct = 38;
  int items_sent = 0;
  int errors = 0;
  int results_seen = 0;
  int jobs_done = 0;
  int done_marks = 0;
  int quanta_used = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // returns 1 when the request changes the job set or yields a result
  function automatic bit apply_request(input logic [rrss_pkg::MODE_W-1:0] mode,
                                       input logic [15:0] burst);
    slice_t            s;
    int                idx;
    bit                hit;
    logic [15:0]       q;
    logic [15:0]       run;
    s = '0;
    hit = 1'b0;
    idx = 0;
    case (mode)
      rrss_pkg::MODE_LOAD: begin
        if (jobs >= MAX_JOBS) return 1'b0;
        burst_mem[jobs] = burst;
        left_mem[jobs] = burst;
        jobs++;
      end
      rrss_pkg::MODE_CLEAR: begin
        jobs = 0;
        now_t = '0;
        scan = 0;
      end
      rrss_pkg::MODE_STEP: begin
        if (scan >= jobs) scan = 0;
        for (int k = 0; k < jobs && !hit; k++) begin
          idx = (scan + k) % jobs;
          if (left_mem[idx] != 0) hit = 1'b1;
        end
        if (!hit) begin
          s.all_done = 1'b1;
        end else begin
          q = (quantum == 0) ? 16'd1 : quantum;
          run = (left_mem[idx] > q) ? q : left_mem[idx];
          left_mem[idx] = left_mem[idx] - run;
          s.job = idx[rrss_pkg::JOB_W-1:0];
          s.t_start = now_t;
          now_t = now_t + run;
          s.t_end = now_t;
          if (left_mem[idx] == 0) begin
            s.fin = 1'b1;
            s.waited = now_t - burst_mem[idx];
            s.tat = burst_mem[idx] + s.waited;
          end
          scan = (idx + 1 >= jobs) ? 0 : idx + 1;
        end
        last_done = !hit;
        slice_q.push_back(s);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic send(input logic [rrss_pkg::MODE_W-1:0] mode, input logic [15:0] burst);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.burst_time <= burst;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (apply_request(mode, burst)) items_sent++;
  endtask

  task automatic set_quantum(input logic [15:0] q);
    req_if.valid <= 1'b0;
    while (slice_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    quantum = q;
    quanta_used++;
    cfg_we <= 1'b0;
  endtask

  task automatic run_until_done(input int max_steps);
    int n;
    n = 0;
    last_done = 1'b0;
    while (!last_done && n < max_steps) begin
      send(rrss_pkg::MODE_STEP, 16'($urandom));
      n++;
    end
  endtask

  function automatic logic [15:0] rand_burst(input int cap);
    if ($urandom_range(9) == 0) return 16'd0;
    return 16'($urandom_range(1, cap));
  endfunction

  task automatic test_empty_set();
    send(rrss_pkg::MODE_STEP, 16'hFFFF);
    send(MODE_NOP, 16'hA5A5);
    send(rrss_pkg::MODE_CLEAR, 16'h0000);
    send(rrss_pkg::MODE_STEP, 16'h0000);
  endtask

  // default quantum of one; a load arrives mid-rotation
  task automatic test_rotation();
    send(rrss_pkg::MODE_LOAD, 16'd2);
    send(rrss_pkg::MODE_LOAD, 16'd0);
    send(rrss_pkg::MODE_LOAD, 16'd3);
    send(rrss_pkg::MODE_STEP, 16'd0);
    send(rrss_pkg::MODE_STEP, 16'd0);
    send(rrss_pkg::MODE_LOAD, 16'd1);
    run_until_done(20);
  endtask

  task automatic test_extremes();
    set_quantum(16'hFFFF);
    send(rrss_pkg::MODE_CLEAR, 16'hFFFF);
    send(rrss_pkg::MODE_LOAD, 16'hFFFF);
    send(rrss_pkg::MODE_LOAD, 16'h0000);
    send(rrss_pkg::MODE_LOAD, 16'h0001);
    run_until_done(4);
  endtask

  task automatic test_zero_quantum();
    set_quantum(16'h0000);
    send(rrss_pkg::MODE_CLEAR, 16'h0000);
    send(rrss_pkg::MODE_LOAD, 16'd2);
    send(rrss_pkg::MODE_LOAD, 16'd1);
    run_until_done(6);
  endtask

  // fill past capacity with long bursts; the clock climbs near its top
  task automatic test_full_set();
    set_quantum(16'hFFFF);
    send(rrss_pkg::MODE_CLEAR, 16'($urandom));
    for (int i = 0; i < MAX_JOBS + 2; i++)
      send(rrss_pkg::MODE_LOAD, (i % 2 == 0) ? 16'hFFFF : 16'($urandom));
    run_until_done(MAX_JOBS + 4);
  endtask

  task automatic run_job_set(input int cap);
    int n;
    int steps;
    int r;
    if ($urandom_range(9) != 0) send(rrss_pkg::MODE_CLEAR, 16'($urandom));
    n = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    repeat (n) send(rrss_pkg::MODE_LOAD, rand_burst(cap));
    steps = 0;
    last_done = 1'b0;
    while (!last_done && steps < 300) begin
      r = $urandom_range(99);
      if (r < 6) send(rrss_pkg::MODE_LOAD, rand_burst(cap));
      else if (r < 9) send(MODE_NOP, 16'($urandom));
      else if (r < 10) send(rrss_pkg::MODE_CLEAR, 16'($urandom));
      else send(rrss_pkg::MODE_STEP, 16'($urandom));
      steps++;
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] q;
    int          cap;
    int          phase;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(5))
        0: q = 16'd1;
        1: q = 16'hFFFF;
        2: q = 16'($urandom);
        default: q = 16'($urandom_range(1, 12));
      endcase
      set_quantum(q);
      cap = (q > 8191 || q == 0) ? 65535 : q * 8;
      gap_pct = (phase == 2) ? 0 : 38;
      repeat (3) run_job_set(cap);
      phase++;
    end
    gap_pct = 38;
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= gap_pct);
  end

  always @(posedge clk) begin
    slice_t got;
    slice_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.job = rsp_if.job_number;
      got.t_start = rsp_if.slice_start;
      got.t_end = rsp_if.slice_end;
      got.fin = rsp_if.job_finished;
      got.waited = rsp_if.waiting_time;
      got.tat = rsp_if.turnaround_time;
      got.all_done = rsp_if.all_done;
      if (slice_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: job=%0d start=%0d end=%0d done=%0b",
                   got.job, got.t_start, got.t_end, got.all_done);
      end else begin
        want = slice_q.pop_front();
        results_seen++;
        if (want.fin) jobs_done++;
        if (want.all_done) done_marks++;
        if (got.job !== want.job || got.t_start !== want.t_start ||
            got.t_end !== want.t_end || got.fin !== want.fin ||
            got.waited !== want.waited || got.tat !== want.tat ||
            got.all_done !== want.all_done) begin
          errors++;
          if (errors <= 10) begin
            $display({"mismatch at %0t: expected job=%0d start=%0d end=%0d fin=%0b",
                      " wait=%0d tat=%0d done=%0b"},
                     $realtime, want.job, want.t_start, want.t_end, want.fin, want.waited,
                     want.tat, want.all_done);
            $display("  actual job=%0d start=%0d end=%0d fin=%0b wait=%0d tat=%0d done=%0b",
                     got.job, got.t_start, got.t_end, got.fin, got.waited, got.tat,
                     got.all_done);
          end
        end
      end
    end
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.mode = rrss_pkg::MODE_LOAD;
    req_if.burst_time = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_set();
    test_rotation();
    test_extremes();
    test_zero_quantum();
    test_full_set();
    test_random_traffic();

    req_if.valid <= 1'b0;
    while (slice_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d requests over %0d quantum settings", items_sent, quanta_used);
    $display("checked %0d results: %0d job completions, %0d all-done markers, %0d errors",
             results_seen, jobs_done, done_marks, errors);
    if (errors == 0 && slice_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
